// ===== hw/rtl/h264rtp_pkg.sv =====
// shared types and constants for the h.264 rtp packetizer
// used by h264rtp_ctrl, h264rtp_dp and h264_rtp_packetizer
`default_nettype none
package h264rtp_pkg;

   localparam int SPS_MAX_BYTES = 40;
   localparam int PPS_MAX_BYTES = 16;
   localparam int SPS_AW = $clog2(SPS_MAX_BYTES);
   localparam int PPS_AW = $clog2(PPS_MAX_BYTES);
   localparam int SPS_LW = $clog2(SPS_MAX_BYTES + 1);
   localparam int PPS_LW = $clog2(PPS_MAX_BYTES + 1);
   localparam int STAP_MAX = 5 + SPS_MAX_BYTES + PPS_MAX_BYTES;
   localparam int STAP_IW = $clog2(STAP_MAX);
   localparam int STAP_TW = $clog2(STAP_MAX + 1);

   // register indexes
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd0;
   localparam logic [1:0] CSR_INIT_SEQ    = 2'd1;

   // unit kinds
   localparam logic [2:0] KIND_IDLE = 3'd0;
   localparam logic [2:0] KIND_SEEK = 3'd1;
   localparam logic [2:0] KIND_SEND = 3'd2;
   localparam logic [2:0] KIND_SPS  = 3'd3;
   localparam logic [2:0] KIND_PPS  = 3'd4;

   // nal types
   localparam logic [4:0] NAL_SLICE = 5'd1;
   localparam logic [4:0] NAL_IDR   = 5'd5;
   localparam logic [4:0] NAL_SPS   = 5'd7;
   localparam logic [4:0] NAL_PPS   = 5'd8;

   // packet kinds
   localparam logic [1:0] PKT_SINGLE = 2'd0;
   localparam logic [1:0] PKT_STAP   = 2'd1;
   localparam logic [1:0] PKT_FU     = 2'd2;

   localparam logic [10:0] MIN_PAYLOAD = 11'd16;
   localparam logic [7:0]  STAP_TYPE   = 8'd24;
   localparam logic [7:0]  FU_TYPE     = 8'd28;
   localparam logic [7:0]  FU_S_BIT    = 8'h80;
   localparam logic [7:0]  FU_E_BIT    = 8'h40;
   localparam logic [7:0]  NRI_MASK    = 8'he0;

   typedef struct packed {
      logic [7:0]  payload;
      logic        is_start;
      logic        is_end;
      logic        marker;
      logic [15:0] seq;
      logic [1:0]  kind;
   } beat_type;

   typedef struct packed {
      logic accept;
      logic stap_emit;
      logic dir_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       has_stap;
      logic [1:0] dir_count;
      logic       stap_last;
      logic       dir_last;
      logic       slot_free;
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/h264_rtp_packetizer.sv =====
// h.264 rtp packetizer: single nal, stap-a and fu-a payloads, one frame byte per beat
// a result goes out through the plan state and the output register; a leading stap-a adds a store read state
// a new byte is taken only after every result of the last one has been emitted,
// and emission waits while rsp_stall holds the output register
// reset: synchronous; clears frame state, stored lengths and sequence, not the stores
`default_nettype none
module h264_rtp_packetizer
   import h264rtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_first,
   input  wire logic [23:0] req_frame_length,
   input  wire logic [31:0] req_frame_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_packet_start,
   output logic             rsp_packet_end,
   output logic             rsp_marker_bit,
   output logic [15:0]      rsp_sequence_number,
   output logic [31:0]      rsp_packet_time,
   output logic [1:0]       rsp_packet_kind,
   output logic             rsp_last_of_input
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   h264rtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   h264rtp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_data_byte       (req_data_byte),
      .req_frame_first     (req_frame_first),
      .req_frame_length    (req_frame_length),
      .req_frame_time      (req_frame_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_packet_start    (rsp_packet_start),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_marker_bit      (rsp_marker_bit),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_packet_time     (rsp_packet_time),
      .rsp_packet_kind     (rsp_packet_kind),
      .rsp_last_of_input   (rsp_last_of_input),
      .cmd                 (cmd),
      .status              (status)
   );

   // a byte's plan is built before the next byte may come in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a plan is pending");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_packet_kind != 2'd3))
      else $error("illegal packet kind");

   // a stap-a always carries at least seven bytes
   a_stap_not_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_kind == PKT_STAP) |-> !(rsp_packet_start && rsp_packet_end))
      else $error("stap-a of one beat");

   a_stap_no_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_kind == PKT_STAP) |-> !rsp_marker_bit)
      else $error("marker on stap-a");

endmodule
`default_nettype wire

// ===== hw/rtl/h264rtp_ctrl.sv =====
// sequencer for the packetizer: accepts a byte, then walks its emission plan
// depends on h264rtp_pkg
`default_nettype none
module h264rtp_ctrl
   import h264rtp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PLAN      = 3'd1;
   localparam logic [2:0] ST_STAP_RD   = 3'd2;
   localparam logic [2:0] ST_STAP_EMIT = 3'd3;
   localparam logic [2:0] ST_DIRECT    = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (status.has_stap) state_in = ST_STAP_RD;
            else if (status.dir_count != 2'd0) state_in = ST_DIRECT;
            else state_in = ST_IDLE;
         end
         // store read data is registered, so it lands in the cycle after the index is set
         ST_STAP_RD: state_in = ST_STAP_EMIT;
         ST_STAP_EMIT: begin
            if (status.slot_free) begin
               cmd.stap_emit = 1'b1;
               if (!status.stap_last) state_in = ST_STAP_RD;
               else if (status.dir_count != 2'd0) state_in = ST_DIRECT;
               else state_in = ST_IDLE;
            end
         end
         ST_DIRECT: begin
            if (status.slot_free) begin
               cmd.dir_emit = 1'b1;
               if (status.dir_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/h264rtp_dp.sv =====
// packetizer datapath: frame state, parameter set stores, plan and output register
// depends on h264rtp_pkg
`default_nettype none
module h264rtp_dp
   import h264rtp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_frame_first,
   input  wire logic [23:0]  req_frame_length,
   input  wire logic [31:0]  req_frame_time,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_packet_start,
   output logic              rsp_packet_end,
   output logic              rsp_marker_bit,
   output logic [15:0]       rsp_sequence_number,
   output logic [31:0]       rsp_packet_time,
   output logic [1:0]        rsp_packet_kind,
   output logic              rsp_last_of_input,
   input  wire ctrl_cmd_type cmd,
   output ctrl_status_type   status
);

   logic [10:0] max_payload_ff;
   logic [23:0] byte_pos_ff, byte_pos_in;
   logic [2:0]  prefix_ff, prefix_in;
   logic [2:0]  kind_ff, kind_in;
   logic        frag_ff, frag_in;
   logic [23:0] bytes_left_ff, bytes_left_in;
   logic [10:0] fill_ff, fill_in;
   logic [7:0]  fi_ff, fi_in;
   logic [7:0]  fh_ff, fh_in;
   logic [15:0] next_seq_ff, next_seq_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [SPS_LW-1:0] sps_len_ff, sps_len_in;
   logic [PPS_LW-1:0] pps_len_ff, pps_len_in;

   logic        has_stap_ff, has_stap_in;
   logic [15:0] stap_seq_ff;
   logic [1:0]  ndir_ff, ndir_in;
   beat_type    beat0_ff, beat1_ff, beat2_ff, beat0_in, beat1_in, beat2_in;
   logic [1:0]  dir_idx_ff;
   logic [STAP_IW-1:0] stap_idx_ff;

   logic [7:0] sps_mem [SPS_MAX_BYTES];
   logic [7:0] pps_mem [PPS_MAX_BYTES];
   logic [7:0] sps_rd_ff, pps_rd_ff;
   logic              sps_we, pps_we;
   logic [SPS_AW-1:0] sps_wa, sps_ra;
   logic [PPS_AW-1:0] pps_wa, pps_ra;

   beat_type    out_ff;
   logic        out_valid_ff;
   logic        out_last_ff;
   logic [31:0] out_time_ff;

   // step logic
   logic [2:0]  k0, p0;
   logic [23:0] bl0, pos0, rest;
   logic        f0, hdr;
   logic [10:0] fl0, mp, fill_add;
   logic [4:0]  ntype;
   logic [15:0] s1, seq_b;
   logic [7:0]  fhn;
   logic        lastf, endf;

   assign mp = (max_payload_ff < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_ff;
   assign ntype = req_data_byte[4:0];

   always_comb begin
      k0   = req_frame_first ? KIND_SEEK : kind_ff;
      bl0  = req_frame_first ? req_frame_length : bytes_left_ff;
      pos0 = req_frame_first ? 24'd0 : byte_pos_ff;
      p0   = req_frame_first ? 3'd0 : prefix_ff;
      f0   = req_frame_first ? 1'b0 : frag_ff;
      fl0  = req_frame_first ? 11'd0 : fill_ff;
      rest = bl0 - 24'd1;
      hdr = 1'b0;
      s1 = next_seq_ff;
      seq_b = 16'd0;
      fhn = fh_ff;
      lastf = 1'b0;
      endf = 1'b0;
      fill_add = 11'd0;

      kind_in = k0;
      bytes_left_in = bl0;
      byte_pos_in = pos0;
      prefix_in = p0;
      frag_in = f0;
      fill_in = fl0;
      fi_in = fi_ff;
      fh_in = fh_ff;
      next_seq_in = next_seq_ff;
      stamp_in = req_frame_first ? req_frame_time : stamp_ff;
      sps_len_in = (req_frame_first && kind_ff == KIND_SPS) ? '0 : sps_len_ff;
      pps_len_in = (req_frame_first && kind_ff == KIND_PPS) ? '0 : pps_len_ff;
      has_stap_in = 1'b0;
      ndir_in = 2'd0;
      beat0_in = '0;
      beat1_in = '0;
      beat2_in = '0;
      sps_we = 1'b0;
      sps_wa = '0;
      pps_we = 1'b0;
      pps_wa = '0;

      if (bl0 == 24'd0) begin
         kind_in = KIND_IDLE;
      end else begin
         bytes_left_in = rest;
         byte_pos_in = pos0 + 24'd1;
         case (k0)
            KIND_SEEK: begin
               if (pos0 == 24'd0) begin
                  if (req_data_byte != 8'd0) hdr = 1'b1;
               end else if (pos0 == 24'd1) begin
                  if (req_data_byte != 8'd0) kind_in = KIND_IDLE;
               end else if (pos0 == 24'd2) begin
                  if (req_data_byte == 8'd1) prefix_in = 3'd3;
                  else if (req_data_byte != 8'd0) kind_in = KIND_IDLE;
               end else if (pos0 == 24'd3) begin
                  if (p0 == 3'd3) hdr = 1'b1;
                  else if (req_data_byte == 8'd1) prefix_in = 3'd4;
                  else kind_in = KIND_IDLE;
               end else if (pos0 == 24'd4 && p0 == 3'd4) begin
                  hdr = 1'b1;
               end else begin
                  kind_in = KIND_IDLE;
               end
               if (hdr) begin
                  kind_in = KIND_IDLE;
                  if (ntype == NAL_SPS) begin
                     if (bl0 <= 24'(SPS_MAX_BYTES)) begin
                        sps_we = 1'b1;
                        fill_in = 11'd1;
                        if (bl0 == 24'd1) sps_len_in = SPS_LW'(1);
                        else begin
                           sps_len_in = '0;
                           kind_in = KIND_SPS;
                        end
                     end
                  end else if (ntype == NAL_PPS) begin
                     if (bl0 <= 24'(PPS_MAX_BYTES)) begin
                        pps_we = 1'b1;
                        fill_in = 11'd1;
                        if (bl0 == 24'd1) pps_len_in = PPS_LW'(1);
                        else begin
                           pps_len_in = '0;
                           kind_in = KIND_PPS;
                        end
                     end
                  end else if (ntype == NAL_IDR || ntype == NAL_SLICE) begin
                     if (ntype == NAL_IDR && sps_len_in != '0 && pps_len_in != '0) begin
                        has_stap_in = 1'b1;
                        s1 = next_seq_ff + 16'd1;
                     end
                     if (bl0 < {13'd0, mp}) begin
                        frag_in = 1'b0;
                        ndir_in = 2'd1;
                        beat0_in = '{payload: req_data_byte, is_start: 1'b1,
                                     is_end: (bl0 == 24'd1), marker: 1'b1,
                                     seq: s1, kind: PKT_SINGLE};
                        next_seq_in = s1 + 16'd1;
                        if (bl0 > 24'd1) kind_in = KIND_SEND;
                     end else begin
                        frag_in = 1'b1;
                        fi_in = (req_data_byte & NRI_MASK) | FU_TYPE;
                        fh_in = FU_S_BIT | {3'd0, ntype};
                        fill_in = 11'd0;
                        kind_in = KIND_SEND;
                        next_seq_in = s1;
                     end
                  end
               end
            end
            KIND_SEND: begin
               if (!f0) begin
                  ndir_in = 2'd1;
                  beat0_in = '{payload: req_data_byte, is_start: 1'b0,
                               is_end: (rest == 24'd0), marker: 1'b1,
                               seq: next_seq_ff - 16'd1, kind: PKT_SINGLE};
                  if (rest == 24'd0) kind_in = KIND_IDLE;
               end else begin
                  fill_add = fl0;
                  seq_b = next_seq_ff - 16'd1;
                  if (fl0 == 11'd0) begin
                     // first byte of a fragment: indicator and header go first
                     if (({1'b0, rest} + 25'd3) <= {14'd0, mp}) fhn = fh_ff | FU_E_BIT;
                     lastf = fhn[6];
                     beat0_in = '{payload: fi_ff, is_start: 1'b1, is_end: 1'b0,
                                  marker: lastf, seq: next_seq_ff, kind: PKT_FU};
                     beat1_in = '{payload: fhn, is_start: 1'b0, is_end: 1'b0,
                                  marker: lastf, seq: next_seq_ff, kind: PKT_FU};
                     next_seq_in = next_seq_ff + 16'd1;
                     seq_b = next_seq_ff;
                     fill_add = 11'd2;
                  end
                  lastf = fhn[6];
                  fill_add = fill_add + 11'd1;
                  endf = (rest == 24'd0) || (!lastf && fill_add >= mp);
                  fill_in = endf ? 11'd0 : fill_add;
                  fh_in = endf ? (fhn & ~FU_S_BIT) : fhn;
                  if (rest == 24'd0) kind_in = KIND_IDLE;
                  if (fl0 == 11'd0) begin
                     ndir_in = 2'd3;
                     beat2_in = '{payload: req_data_byte, is_start: 1'b0, is_end: endf,
                                  marker: lastf, seq: seq_b, kind: PKT_FU};
                  end else begin
                     ndir_in = 2'd1;
                     beat0_in = '{payload: req_data_byte, is_start: 1'b0, is_end: endf,
                                  marker: lastf, seq: seq_b, kind: PKT_FU};
                  end
               end
            end
            KIND_SPS: begin
               if (fl0 < 11'(SPS_MAX_BYTES)) begin
                  sps_we = 1'b1;
                  sps_wa = fl0[SPS_AW-1:0];
               end
               fill_in = fl0 + 11'd1;
               if (rest == 24'd0) begin
                  sps_len_in = fill_in[SPS_LW-1:0];
                  kind_in = KIND_IDLE;
               end
            end
            KIND_PPS: begin
               if (fl0 < 11'(PPS_MAX_BYTES)) begin
                  pps_we = 1'b1;
                  pps_wa = fl0[PPS_AW-1:0];
               end
               fill_in = fl0 + 11'd1;
               if (rest == 24'd0) begin
                  pps_len_in = fill_in[PPS_LW-1:0];
                  kind_in = KIND_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // stap-a byte layout
   logic [STAP_TW-1:0] i7, s7, p7, total_m1;
   logic [7:0] stap_byte;
   logic       stap_last;

   always_comb begin
      i7 = STAP_TW'(stap_idx_ff);
      s7 = STAP_TW'(sps_len_ff);
      p7 = STAP_TW'(pps_len_ff);
      total_m1 = s7 + p7 + STAP_TW'(4);
      stap_last = (i7 == total_m1);
      if (i7 == '0) stap_byte = (sps_rd_ff & NRI_MASK) | STAP_TYPE;
      else if (i7 == STAP_TW'(1)) stap_byte = 8'd0;
      else if (i7 == STAP_TW'(2)) stap_byte = 8'(sps_len_ff);
      else if (i7 < s7 + STAP_TW'(3)) stap_byte = sps_rd_ff;
      else if (i7 == s7 + STAP_TW'(3)) stap_byte = 8'd0;
      else if (i7 == s7 + STAP_TW'(4)) stap_byte = 8'(pps_len_ff);
      else stap_byte = pps_rd_ff;
      if (i7 < STAP_TW'(3) || (i7 - STAP_TW'(3)) >= STAP_TW'(SPS_MAX_BYTES)) sps_ra = '0;
      else sps_ra = SPS_AW'(i7 - STAP_TW'(3));
      pps_ra = PPS_AW'(i7 - s7 - STAP_TW'(5));
   end

   beat_type dir_beat;
   always_comb begin
      case (dir_idx_ff)
         2'd0: dir_beat = beat0_ff;
         2'd1: dir_beat = beat1_ff;
         default: dir_beat = beat2_ff;
      endcase
   end

   assign status.has_stap  = has_stap_ff;
   assign status.dir_count = ndir_ff;
   assign status.stap_last = stap_last;
   assign status.dir_last  = (dir_idx_ff == ndir_ff - 2'd1);
   assign status.slot_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.accept && sps_we) sps_mem[sps_wa] <= req_data_byte;
      if (cmd.accept && pps_we) pps_mem[pps_wa] <= req_data_byte;
      sps_rd_ff <= sps_mem[sps_ra];
      pps_rd_ff <= pps_mem[pps_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= 11'd1388;
         byte_pos_ff <= '0;
         prefix_ff <= '0;
         kind_ff <= KIND_IDLE;
         frag_ff <= 1'b0;
         bytes_left_ff <= '0;
         fill_ff <= '0;
         fi_ff <= '0;
         fh_ff <= '0;
         next_seq_ff <= '0;
         stamp_ff <= '0;
         sps_len_ff <= '0;
         pps_len_ff <= '0;
         has_stap_ff <= 1'b0;
         ndir_ff <= '0;
         dir_idx_ff <= '0;
         stap_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_MAX_PAYLOAD) max_payload_ff <= csr_data[10:0];
         if (csr_valid && csr_index == CSR_INIT_SEQ) next_seq_ff <= csr_data;
         if (cmd.accept) begin
            byte_pos_ff <= byte_pos_in;
            prefix_ff <= prefix_in;
            kind_ff <= kind_in;
            frag_ff <= frag_in;
            bytes_left_ff <= bytes_left_in;
            fill_ff <= fill_in;
            fi_ff <= fi_in;
            fh_ff <= fh_in;
            next_seq_ff <= next_seq_in;
            stamp_ff <= stamp_in;
            sps_len_ff <= sps_len_in;
            pps_len_ff <= pps_len_in;
            has_stap_ff <= has_stap_in;
            ndir_ff <= ndir_in;
            dir_idx_ff <= '0;
            stap_idx_ff <= '0;
         end
         if (cmd.stap_emit) stap_idx_ff <= stap_idx_ff + STAP_IW'(1);
         if (cmd.dir_emit) dir_idx_ff <= dir_idx_ff + 2'd1;
         if (cmd.stap_emit || cmd.dir_emit) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   // plan payload and output beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         stap_seq_ff <= next_seq_ff;
         beat0_ff <= beat0_in;
         beat1_ff <= beat1_in;
         beat2_ff <= beat2_in;
      end
      if (cmd.stap_emit) begin
         out_ff <= '{payload: stap_byte, is_start: (i7 == '0), is_end: stap_last,
                     marker: 1'b0, seq: stap_seq_ff, kind: PKT_STAP};
         out_last_ff <= stap_last && (ndir_ff == 2'd0);
         out_time_ff <= stamp_ff;
      end else if (cmd.dir_emit) begin
         out_ff <= dir_beat;
         out_last_ff <= status.dir_last;
         out_time_ff <= stamp_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_payload_byte    = out_ff.payload;
   assign rsp_packet_start    = out_ff.is_start;
   assign rsp_packet_end      = out_ff.is_end;
   assign rsp_marker_bit      = out_ff.marker;
   assign rsp_sequence_number = out_ff.seq;
   assign rsp_packet_time     = out_time_ff;
   assign rsp_packet_kind     = out_ff.kind;
   assign rsp_last_of_input   = out_last_ff;

endmodule
`default_nettype wire
